FILE: hw/rtl/cyr_pkg.sv
// Shared types and constants of the callback yield reformer.
// Request and result codes, the candidate entry and both channel payloads.
// No dependencies.
`timescale 1ns / 1ps
package cyr_pkg;

  localparam int NUM_LANES_DEF   = 8;
  localparam int NUM_WARPS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_DRAIN = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic RK_YIELD = 1'b0;
  localparam logic RK_DROP  = 1'b1;
  localparam logic [1:0] KIND_PROC = 2'd1;

  typedef struct packed {
    logic [3:0]  warp;
    logic [4:0]  slot;
    logic [2:0]  lane;
    logic [15:0] group;
    logic [1:0]  kind;
  } entry_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  warp_num;
    logic [4:0]  slot_num;
    logic [2:0]  lane_num;
    logic [15:0] table_group;
    logic [1:0]  callback_kind;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  yield_warp;
    logic [15:0] yield_group;
    logic [2:0]  yield_lane;
    logic [1:0]  yield_kind;
    logic        yield_status;
    logic [4:0]  yield_slot;
    logic [7:0]  lane_mask;
    logic        last;
  } out_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/cyr_cell.sv
// One queue cell: holds a candidate entry, shifts from its upper neighbor.
// Depends on cyr_pkg.
`timescale 1ns / 1ps
module cyr_cell
  import cyr_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     nbr,
  input  entry_t     wr_data,
  output entry_t     q
);

  entry_t q_r;

  // load wins over shift: the kept head re-enters at the tail
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q_r <= wr_data;
    end else if (ctrl.shift) begin
      q_r <= nbr;
    end
  end

  assign q = q_r;

endmodule

FILE: hw/rtl/callback_yield_reformer_unit.sv
// Top level of the callback yield reformer: chain of queue cells, warp gates,
// lane record store and the drain sequencer. Depends on cyr_pkg, cyr_cell.
//
// Usage: an input transaction is taken when start is high and busy is low.
// A push on a full queue returns one drop record on the next cycle; a clear
// returns nothing.
// A drain rotates the queue once through the cell chain, one entry per cycle
// (popping at cell 0 and re-entering kept entries at the tail), then, if an
// entry was taken, walks the lanes one per cycle up to the last lane taken,
// emitting a record for each lane taken.
// Results appear on out_item for exactly one cycle with out_valid high; the
// receiver cannot stall. Reset (rst_n low, synchronous) empties the queue
// and clears every warp gate; entry storage is not cleared.
`timescale 1ns / 1ps
module callback_yield_reformer_unit
  import cyr_pkg::*;
#(
  parameter int NUM_LANES   = NUM_LANES_DEF,
  parameter int NUM_WARPS   = NUM_WARPS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  in_t  in_item,
  output logic busy,
  output logic out_valid,
  output out_t out_item
);

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LIW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t                 state_r;
  logic [CW-1:0]          count_r, rem_r;
  logic [NUM_WARPS-1:0]   busy_r;
  logic [NUM_LANES-1:0]   taken_r;
  logic                   found_r;
  logic [3:0]             aw_r;
  logic [15:0]            ag_r;
  logic [LIW-1:0]         idx_r;
  logic [1:0]             lkind_r [NUM_LANES];
  logic [4:0]             lslot_r [NUM_LANES];
  logic                   out_valid_r;
  out_t                   out_r;

  entry_t                 cell_q [QUEUE_DEPTH];
  cell_ctrl_t             cell_ctrl [QUEUE_DEPTH];
  entry_t                 wr_data;
  entry_t                 head;

  logic accept, do_push, warp_ok, lane_ok, full;
  logic head_busy, head_warp_ok, head_match, head_anchor, head_take, rot;
  logic [31:0] taken32;
  logic        lane_hit, lane_last;
  logic [1:0]  sel_kind;
  logic [4:0]  sel_slot;

  assign accept  = start && !busy;
  assign warp_ok = int'(in_item.warp_num) < NUM_WARPS;
  assign lane_ok = int'(in_item.lane_num) < NUM_LANES;
  assign full    = count_r == CW'(QUEUE_DEPTH);
  assign do_push = accept && in_item.req_type == REQ_PUSH && warp_ok && lane_ok && !full;
  assign head    = cell_q[0];
  assign rot     = state_r == S_SCAN && rem_r != '0;

  always_comb begin
    head_busy = 1'b1;
    for (int k = 0; k < NUM_WARPS; k++) begin
      if (k == int'(head.warp)) head_busy = busy_r[k];
    end
    head_warp_ok = int'(head.warp) < NUM_WARPS;
    head_match   = 1'b0;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (k == int'(head.lane)) head_match = !taken_r[k];
    end
    head_match  = head_match && found_r && head.warp == aw_r && head.group == ag_r;
    head_anchor = !found_r && head_warp_ok && !head_busy;
    head_take   = head_match || head_anchor;
  end

  // push writes at the tail; a kept head re-enters at the shrunk tail
  always_comb begin
    if (rot) begin
      wr_data = head;
    end else begin
      wr_data.warp  = in_item.warp_num;
      wr_data.slot  = in_item.slot_num;
      wr_data.lane  = in_item.lane_num;
      wr_data.group = in_item.table_group;
      wr_data.kind  = in_item.callback_kind;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign nbr = wr_data;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    assign cell_ctrl[i].shift = rot;
    assign cell_ctrl[i].load  = (do_push && count_r == CW'(i)) ||
                                (rot && !head_take && (count_r - 1'b1) == CW'(i));
    cyr_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[i]),
      .nbr     (nbr),
      .wr_data (wr_data),
      .q       (cell_q[i])
    );
  end

  // lane walk selection
  always_comb begin
    taken32  = 32'(taken_r);
    lane_hit = taken_r[idx_r];
    lane_last = (taken32 >> (32'(idx_r) + 32'd1)) == 32'd0;
    sel_kind = lkind_r[idx_r];
    sel_slot = lslot_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (rot && head_take) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        if (k == int'(head.lane)) begin
          lkind_r[k] <= head.kind;
          lslot_r[k] <= head.slot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      busy_r      <= '0;
      taken_r     <= '0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_item.req_type)
              REQ_PUSH: begin
                if (warp_ok && lane_ok) begin
                  if (full) begin
                    out_valid_r <= 1'b1;
                    out_r       <= '{result_kind: RK_DROP, default: '0};
                  end else begin
                    count_r <= count_r + 1'b1;
                  end
                end
              end
              REQ_CLEAR: begin
                for (int k = 0; k < NUM_WARPS; k++) begin
                  if (k == int'(in_item.warp_num)) busy_r[k] <= 1'b0;
                end
              end
              REQ_DRAIN: begin
                state_r <= S_SCAN;
                rem_r   <= count_r;
                taken_r <= '0;
                found_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (rem_r != '0) begin
            rem_r <= rem_r - 1'b1;
            if (head_take) begin
              count_r <= count_r - 1'b1;
              for (int k = 0; k < NUM_LANES; k++) begin
                if (k == int'(head.lane)) taken_r[k] <= 1'b1;
              end
            end
            if (head_anchor) begin
              found_r <= 1'b1;
              aw_r    <= head.warp;
              ag_r    <= head.group;
            end
          end else if (found_r) begin
            for (int k = 0; k < NUM_WARPS; k++) begin
              if (k == int'(aw_r)) busy_r[k] <= 1'b1;
            end
            idx_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (lane_hit) begin
            out_valid_r <= 1'b1;
            out_r       <= '{result_kind:  RK_YIELD,
                             yield_warp:   aw_r,
                             yield_group:  ag_r,
                             yield_lane:   3'(idx_r),
                             yield_kind:   sel_kind,
                             yield_status: sel_kind == KIND_PROC,
                             yield_slot:   sel_slot,
                             lane_mask:    lane_last ? taken32[7:0] : 8'd0,
                             last:         lane_last};
          end
          if ((lane_hit && lane_last) || int'(idx_r) == NUM_LANES - 1) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_last_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.lane_mask != 8'd0 || NUM_LANES > 8)
    else $error("last record without lane mask");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind |-> !out_item.last && out_item.lane_mask == 8'd0)
    else $error("drop record carries yield fields");

  a_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.req_type == REQ_PUSH && warp_ok && lane_ok && full
    |=> out_valid && out_item.result_kind)
    else $error("push on full queue not reported");

endmodule

FILE: dv/tb_callback_yield_reformer_unit.sv
// Self-checking testbench of callback_yield_reformer_unit: pushes, clears and
// drains with a local queue predictor, bursty start driving. Depends on cyr_pkg and callback_yield_reformer_unit.
`timescale 1ns / 1ps
module tb_callback_yield_reformer_unit;
  import cyr_pkg::*;

  localparam int LANES = 8;
  localparam int WARPS = 16;
  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  callback_yield_reformer_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item)
  );

  in_t    pending_items[$];
  out_t   expected_records[$];
  entry_t cand_q[$];
  bit     warp_gate[WARPS];
  int     mismatches = 0;
  int     cycles = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  logic   busy_at_edge = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic add_item(input in_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic expect_record(input out_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  // Apply one accepted transaction to the predictor.
  task automatic predict_item(input in_t it);
    entry_t kept[$];
    entry_t e;
    bit [7:0] taken;
    logic [1:0] lkind[LANES];
    logic [4:0] lslot[LANES];
    int anchor;
    out_t r;
    case (req_t'(it.req_type))
      REQ_PUSH: begin
        if (cand_q.size() >= DEPTH) begin
          r = '0;
          r.result_kind = RK_DROP;
          expect_record(r);
        end else begin
          e.warp = it.warp_num; e.slot = it.slot_num; e.lane = it.lane_num;
          e.group = it.table_group; e.kind = it.callback_kind;
          cand_q.insert(cand_q.size(), e);
        end
      end
      REQ_CLEAR: warp_gate[it.warp_num] = 1'b0;
      REQ_DRAIN: begin
        anchor = -1;
        foreach (cand_q[i]) if (anchor < 0 && !warp_gate[cand_q[i].warp]) anchor = i;
        if (anchor >= 0) begin
          e = cand_q[anchor];
          taken = '0;
          foreach (cand_q[i]) begin
            if (cand_q[i].warp == e.warp && cand_q[i].group == e.group &&
                !taken[cand_q[i].lane]) begin
              taken[cand_q[i].lane] = 1'b1;
              lkind[cand_q[i].lane] = cand_q[i].kind;
              lslot[cand_q[i].lane] = cand_q[i].slot;
            end else kept.insert(kept.size(), cand_q[i]);
          end
          cand_q = kept;
          warp_gate[e.warp] = 1'b1;
          for (int l = 0; l < LANES; l++) begin
            if (taken[l]) begin
              r = '0;
              r.result_kind = RK_YIELD;
              r.yield_warp = e.warp;
              r.yield_group = e.group;
              r.yield_lane = 3'(l);
              r.yield_kind = lkind[l];
              r.yield_status = (lkind[l] == KIND_PROC);
              r.yield_slot = lslot[l];
              r.last = ((taken >> (l + 1)) == 0);
              r.lane_mask = r.last ? taken : 8'd0;
              expect_record(r);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_t make_item(input req_t rt, input int warp, input int grp);
    in_t it;
    it.req_type = rt;
    it.warp_num = 4'(warp);
    it.slot_num = 5'($urandom_range(0, 31));
    it.lane_num = 3'($urandom_range(0, 7));
    it.table_group = 16'(grp);
    it.callback_kind = 2'($urandom_range(0, 3));
    return it;
  endfunction

  // Driver: bursts of transactions with random gaps, changes at falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // the held item was taken at the last rising edge
      if (pending_items.size() > 0 && gap_left == 0 && burst_left > 0) begin
        in_item <= pending_items.pop_front();
        burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left == 0) burst_left <= $urandom_range(1, 12);
      end
    end
  end

  // Monitor: accepted transactions and result records at the rising edge.
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (start && !busy) predict_item(in_item);
      if (out_valid) begin
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected record %p", out_item);
        end else if (out_item !== expected_records[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("record mismatch: expected %p actual %p",
                     expected_records[0], out_item);
          void'(expected_records.pop_front());
        end else void'(expected_records.pop_front());
      end
      if (cycles >= CYCLE_LIMIT) begin
        $display("[callback_yield_reformer_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_random(input int n);
    int w;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      w = $urandom_range(0, 3);
      if (pick < 55) add_item(make_item(REQ_PUSH, w, $urandom_range(0, 2)));
      else if (pick < 70) add_item(make_item(REQ_CLEAR, w, 0));
      else if (pick < 92) add_item(make_item(REQ_DRAIN, w, 0));
      else add_item(in_t'($urandom));
    end
  endtask

  initial begin
    in_t it;
    rst_n = 1'b0;
    foreach (warp_gate[i]) warp_gate[i] = 1'b0;
    // Directed: empty drain, extremes, lane collision, busy warp, unknown request.
    add_item(make_item(REQ_DRAIN, 0, 0));
    it = make_item(REQ_PUSH, 15, 16'hFFFF);
    it.lane_num = 3'd7; it.slot_num = 5'd31; it.callback_kind = 2'd3;
    add_item(it);
    it.lane_num = 3'd7; it.slot_num = 5'd0; it.callback_kind = 2'd1;
    add_item(it);
    it = make_item(REQ_PUSH, 15, 16'hFFFF); it.lane_num = 3'd0; it.callback_kind = 2'd1;
    add_item(it);
    it = make_item(REQ_PUSH, 0, 0); it.lane_num = 3'd0; it.callback_kind = 2'd0;
    add_item(it);
    add_item(make_item(REQ_DRAIN, 0, 0));
    add_item(make_item(REQ_DRAIN, 0, 0));
    add_item(make_item(REQ_DRAIN, 0, 0));
    add_item(make_item(REQ_CLEAR, 15, 0));
    add_item(make_item(REQ_CLEAR, 9, 0));
    add_item(make_item(REQ_DRAIN, 0, 0));
    add_item(make_item(REQ_NONE, 3, 0));
    add_item(make_item(REQ_CLEAR, 15, 0));
    add_item(make_item(REQ_CLEAR, 0, 0));
    // Fill past full to provoke drops.
    for (int k = 0; k < 68; k++)
      add_item(make_item(REQ_PUSH, 1 + k % 2, k % 3));
    for (int k = 0; k < 6; k++) add_item(make_item(REQ_DRAIN, 0, 0));
    add_item(make_item(REQ_CLEAR, 1, 0));
    add_item(make_item(REQ_CLEAR, 2, 0));
    for (int k = 0; k < 30; k++) begin
      add_item(make_item(REQ_DRAIN, 0, 0));
      add_item(make_item(REQ_CLEAR, 1 + k % 2, 0));
    end
    queue_random(70);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !start);
    wait (expected_records.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0)
      $display("[callback_yield_reformer_unit] OK");
    else
      $display("[callback_yield_reformer_unit] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cyr_pkg.sv
hw/rtl/cyr_cell.sv
hw/rtl/callback_yield_reformer_unit.sv
dv/tb_callback_yield_reformer_unit.sv
